// ----- hw/rtl/tcgr_pkg.sv -----
// Shared types and constants of the text console glyph renderer.
`default_nettype none
package tcgr_pkg;

  // Fixed field widths.
  localparam int unsigned GLYPH_WIDTH  = 8;
  localparam int unsigned COLOUR_W     = 32;
  localparam int unsigned CODE_W       = 8;
  localparam int unsigned FONT_ADDR_W  = 12;
  localparam int unsigned FONT_DEPTH   = 4096;
  localparam int unsigned CURSOR_W     = 8;
  localparam int unsigned STRIDE_W     = 13;
  localparam int unsigned INDEX_W      = 24;
  localparam int unsigned ACTION_W     = 2;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 32;

  // Action codes.
  localparam logic [ACTION_W-1:0] ACT_CHAR = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_FONT = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_HOME = 2'd2;

  // Control characters.
  localparam logic [CODE_W-1:0] CHR_NUL = 8'h00;
  localparam logic [CODE_W-1:0] CHR_TAB = 8'h09;
  localparam logic [CODE_W-1:0] CHR_LF  = 8'h0A;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FG_COLOUR    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BG_COLOUR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLUMNS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_ROWS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_STRIDE  = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [COLOUR_W-1:0] FG_RESET     = 32'h00FF_FFFF;
  localparam logic [COLOUR_W-1:0] BG_RESET     = 32'h0000_0000;
  localparam logic [CURSOR_W-1:0] COLUMNS_RESET = 8'd80;
  localparam logic [CURSOR_W-1:0] ROWS_RESET    = 8'd30;
  localparam logic [STRIDE_W-1:0] STRIDE_RESET  = 13'd640;

  // Controller to datapath commands.
  typedef struct packed {
    logic accept;  // input beat taken this cycle
    logic setup;   // compute the first pixel index
    logic step;    // output beat taken, move to the next glyph row
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic draw;    // the offered input beat draws a glyph
    logic last;    // current glyph row is the final one
  } dp_status_t;

endpackage
`default_nettype wire

// ----- hw/rtl/tcgr_ram.sv -----
// Generic single write port RAM with registered read.
`default_nettype none
module tcgr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/tcgr_ctrl.sv -----
// Sequencing state machine of the glyph renderer.
`default_nettype none
module tcgr_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire tcgr_pkg::dp_status_t status,
  output tcgr_pkg::dp_cmd_t        cmd
);
  import tcgr_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SETUP = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready   = (state == ST_IDLE);
  assign out_valid  = (state == ST_EMIT);
  assign cmd.accept = in_valid && in_ready;
  assign cmd.setup  = (state == ST_SETUP);
  assign cmd.step   = out_valid && out_ready;

  // Next state: a drawing beat runs setup, then one output beat per glyph row.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.accept && status.draw) begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (cmd.step && status.last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/tcgr_datapath.sv -----
// Cursor, configuration, font store and pixel generation of the renderer.
`default_nettype none
module tcgr_datapath #(
  parameter int unsigned GLYPH_HEIGHT = 16,
  parameter int unsigned FONT_CHARS   = 256
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [tcgr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [tcgr_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic [tcgr_pkg::ACTION_W-1:0]       action,
  input  wire logic [tcgr_pkg::CODE_W-1:0]         char_code,
  input  wire logic [tcgr_pkg::FONT_ADDR_W-1:0]    font_addr,
  input  wire logic [7:0]                          font_bits,
  input  wire tcgr_pkg::dp_cmd_t                   cmd,
  output tcgr_pkg::dp_status_t                     status,
  output logic      [tcgr_pkg::INDEX_W-1:0]        pixel_index,
  output logic      [tcgr_pkg::COLOUR_W-1:0]       pixel_0,
  output logic      [tcgr_pkg::COLOUR_W-1:0]       pixel_1,
  output logic      [tcgr_pkg::COLOUR_W-1:0]       pixel_2,
  output logic      [tcgr_pkg::COLOUR_W-1:0]       pixel_3,
  output logic      [tcgr_pkg::COLOUR_W-1:0]       pixel_4,
  output logic      [tcgr_pkg::COLOUR_W-1:0]       pixel_5,
  output logic      [tcgr_pkg::COLOUR_W-1:0]       pixel_6,
  output logic      [tcgr_pkg::COLOUR_W-1:0]       pixel_7,
  output logic                                     last_row
);
  import tcgr_pkg::*;

  localparam int unsigned RW = $clog2(GLYPH_HEIGHT);
  localparam logic [RW-1:0] LAST_R = RW'(GLYPH_HEIGHT - 1);
  localparam logic [CODE_W:0] FONT_CHARS_V = (CODE_W + 1)'(FONT_CHARS);

  // Configuration registers.
  logic [COLOUR_W-1:0] fg_colour;
  logic [COLOUR_W-1:0] bg_colour;
  logic [CURSOR_W-1:0] text_columns;
  logic [CURSOR_W-1:0] text_rows;
  logic [STRIDE_W-1:0] line_stride;

  always_ff @(posedge clk) begin
    if (rst) begin
      fg_colour    <= FG_RESET;
      bg_colour    <= BG_RESET;
      text_columns <= COLUMNS_RESET;
      text_rows    <= ROWS_RESET;
      line_stride  <= STRIDE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FG_COLOUR:    fg_colour    <= cfg_data;
        REG_BG_COLOUR:    bg_colour    <= cfg_data;
        REG_TEXT_COLUMNS: text_columns <= cfg_data[CURSOR_W-1:0];
        REG_TEXT_ROWS:    text_rows    <= cfg_data[CURSOR_W-1:0];
        REG_LINE_STRIDE:  line_stride  <= cfg_data[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // Cursor and decode of the offered beat.
  logic [CURSOR_W-1:0] cursor_col;
  logic [CURSOR_W-1:0] cursor_row;
  logic [CURSOR_W-1:0] cursor_col_next;
  logic [CURSOR_W-1:0] cursor_row_next;
  logic [CURSOR_W-1:0] cols_eff;
  logic [CURSOR_W:0]   col_adv;
  logic                rows_left;
  logic                is_ctrl;
  logic                is_char;

  assign cols_eff  = (text_columns == '0) ? CURSOR_W'(1) : text_columns;
  assign rows_left = (cursor_row < text_rows);
  assign is_char   = (action == ACT_CHAR) && rows_left;
  assign is_ctrl   = (char_code == CHR_NUL) || (char_code == CHR_LF) ||
                     (char_code == CHR_TAB);
  assign status.draw = is_char && !is_ctrl;

  // Tab jumps to the next multiple of four; a printable code moves one column.
  always_comb begin
    if (char_code == CHR_TAB) begin
      col_adv = {({1'b0, cursor_col[CURSOR_W-1:2]} + (CURSOR_W - 1)'(1)), 2'b00};
    end else begin
      col_adv = {1'b0, cursor_col} + (CURSOR_W + 1)'(1);
    end
  end

  always_comb begin
    cursor_col_next = cursor_col;
    cursor_row_next = cursor_row;
    if (action == ACT_HOME) begin
      cursor_col_next = '0;
      cursor_row_next = '0;
    end else if (is_char && char_code == CHR_LF) begin
      cursor_col_next = '0;
      cursor_row_next = cursor_row + CURSOR_W'(1);
    end else if (is_char && char_code != CHR_NUL) begin
      if (col_adv >= {1'b0, cols_eff}) begin
        cursor_col_next = '0;
        cursor_row_next = cursor_row + CURSOR_W'(1);
      end else begin
        cursor_col_next = col_adv[CURSOR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= '0;
      cursor_row <= '0;
    end else if (cmd.accept) begin
      cursor_col <= cursor_col_next;
      cursor_row <= cursor_row_next;
    end
  end

  // Latch the glyph base address and the cursor position of a drawn character.
  logic [CODE_W-1:0]      glyph;
  logic [FONT_ADDR_W-1:0] glyph_base;
  logic [FONT_ADDR_W-1:0] line_base;
  logic [CURSOR_W-1:0]    draw_col;

  assign glyph = ({1'b0, char_code} >= FONT_CHARS_V) ?
                 CODE_W'({1'b0, char_code} - FONT_CHARS_V) : char_code;

  always_ff @(posedge clk) begin
    if (cmd.accept && status.draw) begin
      glyph_base <= FONT_ADDR_W'(glyph * GLYPH_HEIGHT);
      line_base  <= FONT_ADDR_W'(cursor_row * GLYPH_HEIGHT);
      draw_col   <= cursor_col;
    end
  end

  // Pixel index: one multiply at setup, then one stride per glyph row.
  logic [STRIDE_W+FONT_ADDR_W-1:0] line_prod;
  logic [INDEX_W-1:0]              index_reg;

  assign line_prod = line_base * line_stride;

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      index_reg <= line_prod[INDEX_W-1:0] + INDEX_W'({draw_col, 3'b000});
    end else if (cmd.step) begin
      index_reg <= index_reg + INDEX_W'(line_stride);
    end
  end

  // Glyph row counter.
  logic [RW-1:0] row_cnt;
  logic [RW-1:0] row_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt <= '0;
    end else if (cmd.setup) begin
      row_cnt <= '0;
    end else if (cmd.step) begin
      row_cnt <= row_cnt + RW'(1);
    end
  end

  assign status.last = (row_cnt == LAST_R);

  // Read one row ahead when a beat is taken so the font data is ready next cycle.
  assign row_rd = cmd.setup ? '0 : (cmd.step ? row_cnt + RW'(1) : row_cnt);

  logic [FONT_ADDR_W-1:0] font_raddr;
  logic [7:0]             font_rdata;

  assign font_raddr = glyph_base + FONT_ADDR_W'(row_rd);

  tcgr_ram #(
    .WIDTH (8),
    .DEPTH (FONT_DEPTH)
  ) u_font (
    .clk   (clk),
    .we    (cmd.accept && (action == ACT_FONT)),
    .waddr (font_addr),
    .wdata (font_bits),
    .raddr (font_raddr),
    .rdata (font_rdata)
  );

  // Expand the glyph row into colours, leftmost pixel from the top bit.
  assign pixel_index = index_reg;
  assign pixel_0     = font_rdata[7] ? fg_colour : bg_colour;
  assign pixel_1     = font_rdata[6] ? fg_colour : bg_colour;
  assign pixel_2     = font_rdata[5] ? fg_colour : bg_colour;
  assign pixel_3     = font_rdata[4] ? fg_colour : bg_colour;
  assign pixel_4     = font_rdata[3] ? fg_colour : bg_colour;
  assign pixel_5     = font_rdata[2] ? fg_colour : bg_colour;
  assign pixel_6     = font_rdata[1] ? fg_colour : bg_colour;
  assign pixel_7     = font_rdata[0] ? fg_colour : bg_colour;
  assign last_row    = status.last;

endmodule
`default_nettype wire

// ----- hw/rtl/text_console_glyph_renderer_core.sv -----
// Top level of the text console glyph renderer.
//
// Input channel (in_valid/in_ready) takes one action per beat: a character,
// a font byte write or a cursor home. Output channel (out_valid/out_ready)
// delivers one beat per glyph row of a drawn character: pixel index, eight
// colour pixels and last_row on the final row.
// Font writes, home, control characters and dropped characters are taken in
// the idle state and produce no output. A printable character is accepted,
// passes through the setup state for the pixel index multiply, then streams
// GLYPH_HEIGHT beats, one per cycle while out_ready is high, read row by row
// from the single font RAM read port. The first beat follows the setup state;
// the next input beat waits until the final row's beat is taken. When the
// receiver stalls, the current beat holds and the font read address stays
// put. Reset (rst, synchronous) homes the cursor and restores the
// configuration defaults; the font RAM is not cleared and must be written
// before its entries are drawn. The user must write configuration through
// cfg_we, cfg_index and cfg_data while the block is idle; it is not enforced.
`default_nettype none
module text_console_glyph_renderer_core #(
  parameter int unsigned GLYPH_HEIGHT = 16,
  parameter int unsigned FONT_CHARS   = 256
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [tcgr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [tcgr_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [tcgr_pkg::ACTION_W-1:0]       action,
  input  wire logic [tcgr_pkg::CODE_W-1:0]         char_code,
  input  wire logic [tcgr_pkg::FONT_ADDR_W-1:0]    font_addr,
  input  wire logic [7:0]                          font_bits,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic      [tcgr_pkg::INDEX_W-1:0]        pixel_index,
  output logic      [tcgr_pkg::COLOUR_W-1:0]       pixel_0,
  output logic      [tcgr_pkg::COLOUR_W-1:0]       pixel_1,
  output logic      [tcgr_pkg::COLOUR_W-1:0]       pixel_2,
  output logic      [tcgr_pkg::COLOUR_W-1:0]       pixel_3,
  output logic      [tcgr_pkg::COLOUR_W-1:0]       pixel_4,
  output logic      [tcgr_pkg::COLOUR_W-1:0]       pixel_5,
  output logic      [tcgr_pkg::COLOUR_W-1:0]       pixel_6,
  output logic      [tcgr_pkg::COLOUR_W-1:0]       pixel_7,
  output logic                                     last_row
);
  import tcgr_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer.
  tcgr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath.
  tcgr_datapath #(
    .GLYPH_HEIGHT (GLYPH_HEIGHT),
    .FONT_CHARS   (FONT_CHARS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .action      (action),
    .char_code   (char_code),
    .font_addr   (font_addr),
    .font_bits   (font_bits),
    .cmd         (cmd),
    .status      (status),
    .pixel_index (pixel_index),
    .pixel_0     (pixel_0),
    .pixel_1     (pixel_1),
    .pixel_2     (pixel_2),
    .pixel_3     (pixel_3),
    .pixel_4     (pixel_4),
    .pixel_5     (pixel_5),
    .pixel_6     (pixel_6),
    .pixel_7     (pixel_7),
    .last_row    (last_row)
  );

endmodule
`default_nettype wire
